// ===== rtl/core/edma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared constants and types for the echo distance moving average
// no dependencies; used by edma_div and echo_distance_moving_average

package edma_pkg;

    // field widths
    localparam int ECHO_W   = 20;
    localparam int DIST_W   = 8;
    localparam int DIST_MAX = 255;

    // default averaging window
    localparam int WINDOW_DEF = 40;

    // distance scaling: cm = floor(us * 17 / 1000)
    localparam int CM_NUM    = 17;
    localparam int CM_DEN    = 1000;
    localparam int SCALED_W  = ECHO_W + 5;
    // scaled values at or above this clamp to the maximum distance
    localparam int SCALE_LIMIT = (DIST_MAX + 1) * CM_DEN;
    localparam int SMALL_W   = 18;
    // ceil(2^32 / 1000): exact quotient for every operand below SCALE_LIMIT
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP = 23'd4294968;
    localparam int PROD_W      = SMALL_W + RECIP_W;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } edma_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/edma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// generic single-write, single-read ram with registered read data
// no dependencies

module edma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/edma_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// radix-2 restoring divider, one quotient bit per cycle
// depends on edma_pkg for the status struct

module edma_div
    import edma_pkg::*;
#(
    parameter int NUM_W = 14,
    parameter int DEN_W = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output edma_div_stat_t        stat,
    output logic      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_sh_reg, num_sh_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_sh_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        num_sh_next = num_sh_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = CNT_W'(NUM_W);
            num_sh_next = num;
            rem_next    = '0;
            den_next    = den;
        end else if (busy_reg) begin
            rem_next    = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_sh_next = {num_sh_reg[NUM_W-2:0], ge};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_sh_reg <= num_sh_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = num_sh_reg;

endmodule

`default_nettype wire

// ===== rtl/core/echo_distance_moving_average.sv =====
`timescale 1ns / 1ps
`default_nettype none
// echo distance moving average: one echo width in, one averaged distance out
//
// s_ channel: one transfer per echo pulse width (microseconds, 20 bits)
// m_ channel: one transfer per input, the truncated mean of the last
//   WINDOW clamped distances in centimeters (fewer while warming up)
// each input is scaled to cm as floor(us*17/1000), clamped to 255,
//   written into a ring ram; the oldest entry is read back in the same
//   pass and taken out of the running sum once the window is full
// processing: the input is registered, then scaled, multiplied, the ring and
//   sum updated, divided by the one-bit-per-cycle divider over SUM_W bits
//   (the running sum width, 14 bits for a 40-entry window), and registered out
// a new item is taken only after the previous one has left S_OUT;
//   s_tready is high only while no item is in flight
// reset (aresetn low, synchronous) clears position, fill count, sum and
//   the output valid; ring ram contents are not cleared and never need to be
// a stalled receiver: the result sits in the output register; a new input
//   is still taken and processed, and its result waits until the register
//   frees up

module echo_distance_moving_average
    import edma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [19:0] echo_us, [23:20] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [7:0] avg_distance
);

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = $clog2(DIST_MAX * WINDOW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_MUL,
        S_UPDATE,
        S_DIV,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [ECHO_W-1:0]   echo_reg, echo_next;
    logic                over_reg, over_next;
    logic [SMALL_W-1:0]  small_reg, small_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]   m_data_reg, m_data_next;

    logic                s_accept;
    logic                full;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    logic [DIST_W-1:0]   ring_rd;
    logic [DIST_W-1:0]   oldest;
    logic                ring_we;
    logic                div_start;
    edma_div_stat_t      div_stat;
    logic [SUM_W-1:0]    div_quo;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (fill_reg == CNT_W'(WINDOW));

    // us * 17 as shift and add
    assign scaled = (SCALED_W'(echo_reg) << 4) + SCALED_W'(echo_reg);
    // divide by 1000 through the reciprocal, exact below the clamp limit
    assign prod   = PROD_W'(small_reg) * PROD_W'(RECIP);

    // oldest entry only counts once the ring has been filled
    assign oldest = full ? ring_rd : '0;

    // ring of distances; the read of the slot about to be overwritten is
    // issued on the input transfer and its data held until the update
    edma_ram #(
        .WIDTH (DIST_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (pos_reg),
        .wr_data (dist_reg),
        .rd_en   (s_accept),
        .rd_addr (pos_reg),
        .rd_data (ring_rd)
    );

    edma_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_next),
        .den     (fill_next),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    always_comb begin
        state_next   = state_reg;
        echo_next    = echo_reg;
        over_next    = over_reg;
        small_next   = small_reg;
        dist_next    = dist_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        ring_we      = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    echo_next  = s_tdata[ECHO_W-1:0];
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                over_next  = (scaled >= SCALED_W'(SCALE_LIMIT));
                small_next = scaled[SMALL_W-1:0];
                state_next = S_MUL;
            end
            S_MUL: begin
                // far target clamps to the top distance
                dist_next  = over_reg ? DIST_W'(DIST_MAX) : prod[RECIP_SHIFT +: DIST_W];
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                // read-modify-write of the ring slot and running sum
                sum_next  = sum_reg + SUM_W'(dist_reg) - SUM_W'(oldest);
                ring_we   = 1'b1;
                pos_next  = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);
                fill_next = full ? fill_reg : fill_reg + CNT_W'(1);
                div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // output register free or being emptied this cycle
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = div_quo[DIST_W-1:0];
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        echo_reg   <= echo_next;
        over_reg   <= over_next;
        small_reg  <= small_next;
        dist_reg   <= dist_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // fill count saturates at the window length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    // running sum never exceeds the largest distance times the entries held
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_W'(DIST_MAX) * SUM_W'(fill_reg))
        else $error("running sum out of range");

    // an accepted item always moves straight into scaling
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_SCALE))
        else $error("accepted item not processed");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    // the mean always fits the distance field
    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (div_quo <= SUM_W'(DIST_MAX)))
        else $error("average exceeds distance range");

endmodule

`default_nettype wire

// ===== tb/echo_average_checker.sv =====
`timescale 1ns / 1ps
// checker for echo_distance_moving_average: watches both stream channels, keeps
// its own window of distances and compares every averaged distance it predicts
// depends on edma_pkg for field widths, the distance clamp and the default window

module echo_average_checker
    import edma_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [19:0] echo_us, [23:20] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] avg_distance
    output int          fail_count,
    output int          pending
);

    // sound travels 0.034 cm/us, halved for the round trip
    localparam int US_TO_CM_NUM = 17;
    localparam int US_TO_CM_DEN = 1000;

    logic [DIST_W-1:0] dist_ring [WINDOW_DEF];
    int unsigned       ring_pos  = 0;
    int unsigned       ring_fill = 0;
    int unsigned       dist_sum  = 0;
    logic [DIST_W-1:0] expected_averages [$];
    int                n_errors  = 0;

    function automatic logic [DIST_W-1:0] echo_to_distance(logic [ECHO_W-1:0] us);
        int unsigned cm;
        cm = 32'(us) * US_TO_CM_NUM / US_TO_CM_DEN;
        return (cm > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(cm);
    endfunction

    // add one distance to the window and return the new truncated mean
    function logic [DIST_W-1:0] average_after(logic [DIST_W-1:0] dist_cm);
        dist_sum += dist_cm;
        if (ring_fill == WINDOW_DEF)
            dist_sum -= dist_ring[ring_pos];
        dist_ring[ring_pos] = dist_cm;
        ring_pos = (ring_pos == WINDOW_DEF - 1) ? 0 : ring_pos + 1;
        if (ring_fill < WINDOW_DEF)
            ring_fill++;
        return DIST_W'(dist_sum / ring_fill);
    endfunction

    always @(posedge aclk) begin : track
        logic [DIST_W-1:0] want;
        if (!aresetn) begin
            ring_pos  = 0;
            ring_fill = 0;
            dist_sum  = 0;
            expected_averages.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_averages.push_back(average_after(echo_to_distance(s_tdata[ECHO_W-1:0])));
            if (m_tvalid && m_tready) begin
                if (expected_averages.size() == 0) begin
                    n_errors++;
                    $display("%0t: avg_distance expected none, got %0d", $time, m_tdata);
                end else begin
                    want = expected_averages.pop_front();
                    if (m_tdata !== want) begin
                        n_errors++;
                        $display("%0t: avg_distance expected %0d, got %0d",
                                 $time, want, m_tdata);
                    end
                end
            end
        end
        fail_count <= n_errors;
        pending    <= expected_averages.size();
    end

endmodule

// ===== tb/echo_distance_moving_average_test.sv =====
`timescale 1ns / 1ps
// testbench top for echo_distance_moving_average: clock, reset, echo stimulus,
// result back-pressure, watchdog and verdict
// depends on edma_pkg, echo_distance_moving_average and echo_average_checker

module echo_distance_moving_average_test;
    import edma_pkg::*;

    localparam int N_RANDOM      = 800;
    localparam int DRAIN_AT      = 400;   // random transfers before the mid-run drain
    localparam int HOLD_AFTER    = 150;   // results taken before the long receiver hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;    // settling after the last result
    localparam int IDLE_LIMIT    = 3000;

    // what a burst of echoes looks like
    typedef enum {
        ECHO_MIXED,         // kind chosen per transfer
        ECHO_ANY,           // full 20-bit range, mostly clamped
        ECHO_IN_RANGE,      // distances 0..255 cm
        ECHO_TIMEOUT,       // zero width
        ECHO_NEAR_CLAMP,    // around the 255 cm boundary
        ECHO_FAR            // always clamped
    } echo_kind_e;

    // receiver back-pressure shapes
    typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_TOGGLE} ready_pattern_e;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [19:0] echo_us, [23:20] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] avg_distance
    int          fail_count;
    int          pending;

    echo_distance_moving_average u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    echo_average_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // offer one echo and hold it until the block takes the transfer
    task automatic send_echo(input logic [ECHO_W-1:0] us);
        s_tdata  <= {4'b0000, us};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender goes quiet until every predicted average has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic logic [ECHO_W-1:0] pick_echo(echo_kind_e kind);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (kind == ECHO_MIXED)
            kind = (r < 2) ? ECHO_ANY : (r < 7) ? ECHO_IN_RANGE :
                   (r == 7) ? ECHO_TIMEOUT : (r == 8) ? ECHO_NEAR_CLAMP : ECHO_FAR;
        case (kind)
            ECHO_ANY:        return ECHO_W'($urandom());
            ECHO_IN_RANGE:   return ECHO_W'($urandom_range(0, 15100));
            ECHO_TIMEOUT:    return '0;
            ECHO_NEAR_CLAMP: return ECHO_W'($urandom_range(14900, 15200));
            default:         return ECHO_W'($urandom_range(15060, (1 << ECHO_W) - 1));
        endcase
    endfunction

    initial begin : stimulus
        int          sent;
        int          burst_len;
        int          gap;
        int unsigned r;
        echo_kind_e  burst_kind;
        logic        drained;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, sent back to back; the first items also walk the warm-up
        send_echo(20'd0);           // timeout as the very first sample
        send_echo(20'd0);
        send_echo(20'd1);
        send_echo(20'd58);          // just below 1 cm
        send_echo(20'd59);          // first width giving 1 cm
        send_echo(20'd588);
        send_echo(20'd589);
        send_echo(20'd1000);
        send_echo(20'd14999);
        send_echo(20'd15000);       // exactly 255 cm
        send_echo(20'd15058);       // last width below the clamp
        send_echo(20'd15059);       // 256 cm, clamped
        send_echo(20'd15060);
        send_echo(20'd30000);
        send_echo(20'h80000);
        send_echo(20'hFFFFF);       // widest echo
        send_echo(20'h55555);
        send_echo(20'hAAAAA);
        send_echo(20'd7);
        wait_drained();

        // random part: bursts of one kind or mixed, some long enough to fill the window
        sent    = 0;
        drained = 1'b0;
        while (sent < N_RANDOM) begin
            burst_len  = $urandom_range(1, 48);
            r          = $urandom_range(0, 9);
            burst_kind = (r < 6) ? ECHO_MIXED : (r == 6) ? ECHO_IN_RANGE :
                         (r == 7) ? ECHO_FAR : (r == 8) ? ECHO_TIMEOUT : ECHO_NEAR_CLAMP;
            for (int i = 0; i < burst_len && sent < N_RANDOM; i++) begin
                send_echo(pick_echo(burst_kind));
                sent++;
            end
            if (!drained && sent >= DRAIN_AT) begin
                drained = 1'b1;
                wait_drained();
            end else begin
                // a third of the bursts follow on with no gap at all
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: segments of random back-pressure, plus one long hold-off
    // while the sender keeps offering, so the block fills and stalls its input
    initial begin : result_sink
        int             seg_left;
        int             rx_seen;
        logic           held_off;
        ready_pattern_e seg_kind;

        m_tready <= 1'b0;
        seg_left = 0;
        rx_seen  = 0;
        held_off = 1'b0;
        seg_kind = RDY_ALWAYS;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (m_tvalid && m_tready)
                rx_seen++;
            if (!held_off && rx_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 60);
                    seg_kind = ready_pattern_e'($urandom_range(0, 3));
                end
                case (seg_kind)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RDY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_tready <= !m_tready;
                endcase
                seg_left--;
                @(posedge aclk);
            end
        end
    end

    // ends the run when no transfer happens on either side for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/edma_pkg.sv
rtl/core/edma_ram.sv
rtl/core/edma_div.sv
rtl/core/echo_distance_moving_average.sv
tb/echo_average_checker.sv
tb/echo_distance_moving_average_test.sv
